/* design/vconv3_pkg.sv */
package vconv3_pkg;

  localparam int PIX_W       = 8;
  localparam int COEF_W      = 16;
  localparam int KERNEL_SIZE = 3;
  localparam int KROW_W      = KERNEL_SIZE * COEF_W;
  localparam int PROD_W      = 24;
  localparam int RSUM_W      = 26;
  localparam int SUM_W       = 28;
  localparam int IMG_W_W     = 12;
  localparam int IMG_H_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 40;

  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Register map.
  localparam cfg_idx_t CFG_IMAGE_WIDTH   = 3'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT  = 3'd1;
  localparam cfg_idx_t CFG_KERNEL_TOP    = 3'd2;
  localparam cfg_idx_t CFG_KERNEL_MIDDLE = 3'd3;
  localparam cfg_idx_t CFG_KERNEL_BOTTOM = 3'd4;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

  // Coefficient of one kernel column from a packed kernel row.
  function automatic coef_t coef_at(input logic [KROW_W-1:0] row_bits, input int col);
    coef_at = coef_t'(row_bits[col*COEF_W +: COEF_W]);
  endfunction

  // Signed Q20.8 sum to an integer pixel: nearest with ties to even, then clamp to 0..255.
  function automatic pix_t round_sat(input sum_t s);
    logic signed [SUM_W-8:0] q;
    logic [7:0]              frac;
    logic                    inc;
    logic signed [SUM_W-8:0] r;
    q    = (SUM_W-7)'(s[SUM_W-1:8]);
    q    = {s[SUM_W-1], s[SUM_W-1:8]};
    frac = s[7:0];
    inc  = (frac > 8'd128) || ((frac == 8'd128) && q[0]);
    r    = q + (SUM_W-7)'(inc);
    if (r[SUM_W-8]) begin
      round_sat = '0;
    end else if (r > (SUM_W-7)'(255)) begin
      round_sat = 8'd255;
    end else begin
      round_sat = r[7:0];
    end
  endfunction

endpackage

/* design/vconv3_ram.sv */
module vconv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/valid_convolution_3x3_core.sv */
// Channel  Dir  Signals                               Content
// s_axis   in   tvalid, tready, tdata[7:0], tuser     pixel_in; tuser = frame_start
// m_axis   out  tvalid, tready, tdata[39:0], tlast    full_sum, pixel_out; tlast = last_of_frame
// cfg      in   valid, ready, index[2:0], data[47:0]  register writes, always ready
//
// One pixel is taken per clock while the output side keeps up.
// The transfer edge of a pixel starts its line memory read; window, products, row sums,
// full sum and rounding take one register each before the result reaches the output.
// Reset clears counters, stage valid bits and the configuration registers; no clearing pass is needed.
// Each stage holds when the one after it is full and held, so a stall at the output
// fills the pipeline before the input side stops.
module valid_convolution_3x3_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [vconv3_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,   // [7:0] pixel_in
  input  logic                               s_axis_tuser_i,   // [0] frame_start
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [vconv3_pkg::M_TDATA_W-1:0]   m_axis_tdata_o, // [27:0] full_sum, [35:28] pixel_out
  output logic                               m_axis_tlast_o,   // [0] last_of_frame
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vconv3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vconv3_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import vconv3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  // Configuration registers.
  logic [IMG_W_W-1:0] img_width_q;
  logic [IMG_H_W-1:0] img_height_q;
  logic [KROW_W-1:0]  kern_q [KERNEL_SIZE];

  // Frame position counters.
  logic [CW-1:0]      col_q;
  logic [IMG_H_W-1:0] row_q;

  // Stage 1: pixel waiting for the line memory read data.
  logic          s1_v_q;
  pix_t          s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_prod_q;
  logic          s1_last_q;
  logic          s1_fwd_q;
  pix_t          fwd_pix_q;

  // Window stage; the window itself is the payload.
  logic win_v_q;
  logic win_last_q;
  pix_t win_q [KERNEL_SIZE][KERNEL_SIZE];

  // Arithmetic stages.
  logic  prod_v_q, prod_last_q;
  prod_t prod_q [KERNEL_SIZE][KERNEL_SIZE];
  logic  rs_v_q, rs_last_q;
  rsum_t rs_q [KERNEL_SIZE];
  logic  sum_v_q, sum_last_q;
  sum_t  sum_q;

  // Output register.
  logic out_v_q, out_last_q;
  sum_t out_sum_q;
  pix_t out_pix_q;

  // Stage enables: a stage may load when it is empty or its content moves on.
  logic out_en, sum_en, rs_en, prod_en, win_en;
  logic in_fire, s1_go;

  assign out_en  = !out_v_q || m_axis_tready_i;
  assign sum_en  = !sum_v_q || out_en;
  assign rs_en   = !rs_v_q || sum_en;
  assign prod_en = !prod_v_q || rs_en;
  assign win_en  = !win_v_q || prod_en;
  assign s_axis_tready_o = !s1_v_q || win_en;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_go   = s1_v_q && win_en;

  // Position of the incoming pixel and the end-of-row and end-of-frame decisions.
  logic [CW-1:0]      col_c;
  logic [IMG_H_W-1:0] row_c;
  logic [WB-1:0]      w_ext, w_sat, w_last;
  logic [IMG_H_W-1:0] h_last;
  logic               row_end_c, frame_end_c, produce_c;

  always_comb begin
    col_c = s_axis_tuser_i ? '0 : col_q;
    row_c = s_axis_tuser_i ? '0 : row_q;
    w_ext = WB'(img_width_q);
    if (w_ext < WB'(3)) begin
      w_sat = WB'(3);
    end else if (w_ext > WB'(MAX_WIDTH)) begin
      w_sat = WB'(MAX_WIDTH);
    end else begin
      w_sat = w_ext;
    end
    w_last = w_sat - WB'(1);
    h_last = (img_height_q < IMG_H_W'(3)) ? IMG_H_W'(2) : img_height_q - IMG_H_W'(1);
    row_end_c   = WB'(col_c) >= w_last;
    frame_end_c = row_end_c && (row_c >= h_last);
    produce_c   = (row_c >= IMG_H_W'(2)) && (col_c >= CW'(2));
  end

  // Line memories: line 1 holds the row above, line 2 the row above that.
  pix_t line1_rdata, line2_rdata;
  pix_t above1, above2;

  vconv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (col_c),
    .wdata_i (s_axis_tdata_i[PIX_W-1:0]),
    .re_i    (in_fire),
    .raddr_i (col_c),
    .rdata_o (line1_rdata)
  );

  // Line 2 is written when the pixel leaves stage 1, with what line 1 held there.
  vconv3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line2 (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (line1_rdata),
    .re_i    (in_fire),
    .raddr_i (col_c),
    .rdata_o (line2_rdata)
  );

  // When two transfers in a row hit the same column, the line 2 read races
  // the deferred write of the earlier pixel, so that value is forwarded.
  assign above1 = line1_rdata;
  assign above2 = s1_fwd_q ? fwd_pix_q : line2_rdata;

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= IMAGE_WIDTH_RST;
      img_height_q <= IMAGE_HEIGHT_RST;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        kern_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:   img_width_q  <= cfg_data_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT:  img_height_q <= cfg_data_i[IMG_H_W-1:0];
        CFG_KERNEL_TOP:    kern_q[0]    <= cfg_data_i[KROW_W-1:0];
        CFG_KERNEL_MIDDLE: kern_q[1]    <= cfg_data_i[KROW_W-1:0];
        CFG_KERNEL_BOTTOM: kern_q[2]    <= cfg_data_i[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Counters and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      s1_v_q    <= 1'b0;
      s1_fwd_q  <= 1'b0;
      win_v_q   <= 1'b0;
      prod_v_q  <= 1'b0;
      rs_v_q    <= 1'b0;
      sum_v_q   <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        if (frame_end_c) begin
          col_q <= '0;
          row_q <= '0;
        end else if (row_end_c) begin
          col_q <= '0;
          row_q <= row_c + IMG_H_W'(1);
        end else begin
          col_q <= col_c + CW'(1);
          row_q <= row_c;
        end
        s1_fwd_q <= s1_v_q && (s1_col_q == col_c);
      end
      if (s_axis_tready_o) begin
        s1_v_q <= s_axis_tvalid_i;
      end
      if (win_en) begin
        win_v_q <= s1_go && s1_prod_q;
      end
      if (prod_en) begin
        prod_v_q <= win_v_q;
      end
      if (rs_en) begin
        rs_v_q <= prod_v_q;
      end
      if (sum_en) begin
        sum_v_q <= rs_v_q;
      end
      if (out_en) begin
        out_v_q <= sum_v_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= s_axis_tdata_i[PIX_W-1:0];
      s1_col_q  <= col_c;
      s1_prod_q <= produce_c;
      s1_last_q <= frame_end_c;
      fwd_pix_q <= line1_rdata;
    end
    if (s1_go) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
      end
      win_q[0][KERNEL_SIZE-1] <= above2;
      win_q[1][KERNEL_SIZE-1] <= above1;
      win_q[2][KERNEL_SIZE-1] <= s1_pix_q;
      win_last_q <= s1_last_q;
    end
    if (prod_en && win_v_q) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        for (int c = 0; c < KERNEL_SIZE; c++) begin
          // Both operands are widened first so the product keeps all of its bits.
          prod_q[r][c] <= prod_t'($signed({1'b0, win_q[r][c]}))
                          * prod_t'(coef_at(kern_q[r], c));
        end
      end
      prod_last_q <= win_last_q;
    end
    if (rs_en && prod_v_q) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        rs_q[r] <= RSUM_W'(prod_q[r][0]) + RSUM_W'(prod_q[r][1]) + RSUM_W'(prod_q[r][2]);
      end
      rs_last_q <= prod_last_q;
    end
    if (sum_en && rs_v_q) begin
      sum_q      <= SUM_W'(rs_q[0]) + SUM_W'(rs_q[1]) + SUM_W'(rs_q[2]);
      sum_last_q <= rs_last_q;
    end
    if (out_en && sum_v_q) begin
      out_sum_q  <= sum_q;
      out_pix_q  <= round_sat(sum_q);
      out_last_q <= sum_last_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - SUM_W - PIX_W)'(0), out_pix_q, out_sum_q};
  assign m_axis_tlast_o  = out_last_q;

  // The last pixel of a frame sends both counters home.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && frame_end_c |=> (col_q == '0) && (row_q == '0))
    else $error("counters not cleared after the last pixel of a frame");

  // Inside a row the column advances by exactly one.
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !s_axis_tuser_i && !row_end_c |=> col_q == $past(col_q) + CW'(1))
    else $error("column counter skipped inside a row");

  // A pixel outside the valid area must not enter the arithmetic stages.
  a_no_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && !s1_prod_q |=> !win_v_q)
    else $error("border pixel entered the window stage");

  // A negative sum always rounds to a black pixel.
  a_neg_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_sum_q[SUM_W-1] |-> out_pix_q == '0)
    else $error("negative sum gave a nonzero pixel");

endmodule
